// ===== src/hec_pkg.sv =====
// Shared constants, types and step-angle functions for the coordinate converter.
`default_nettype none
package hec_pkg;
    localparam int PORT_BITS     = 32;
    localparam int ANGLE_BITS    = 32;
    localparam int CORDIC_STAGES = 28;
    localparam int FRAC_BITS     = 30;
    localparam int VAL_BITS      = 34;
    localparam int SQRT_STAGES   = FRAC_BITS + 1;
    localparam int RAD_BITS      = 2 * FRAC_BITS + 1;
    localparam int RES_BITS      = 2 * FRAC_BITS + 2;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [31:0] CORDIC_GAIN    = 32'h26DD3B6A;
    localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

    localparam logic OP_EQU_TO_HOR = 1'b0;
    localparam logic OP_HOR_TO_EQU = 1'b1;

    localparam logic [CFG_ADDR_BITS-3:0] REG_SITE_LATITUDE = '0;

    typedef logic signed [VAL_BITS-1:0] t_val;

    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p00, p01, p10, p11, mid;
        p00 = 64'(a[31:0]) * 64'(b[31:0]);
        p01 = 64'(a[31:0]) * 64'(b[63:32]);
        p10 = 64'(a[63:32]) * 64'(b[31:0]);
        p11 = 64'(a[63:32]) * 64'(b[63:32]);
        mid = (p00 >> 32) + 64'(p01[31:0]) + 64'(p10[31:0]);
        return p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
    endfunction

    function automatic logic [63:0] step_angle(input int idx, input int ab);
        logic [63:0] rad;
        logic [63:0] term;
        logic [63:0] prod;
        int          e;
        rad = PI_Q60;
        if (idx > 0) begin
            rad = '0;
            for (int k = 0; k < 64; k++) begin
                e = idx * (2 * k + 1);
                if (e <= 62) begin
                    term = div_u64(64'd1 << (62 - e), 64'(2 * k + 1));
                    if ((k & 1) == 1) begin
                        rad = rad - term;
                    end else begin
                        rad = rad + term;
                    end
                end
            end
        end
        prod = mul_hi(rad, INV_TWO_PI_Q64);
        return (prod + (64'd1 << (61 - ab))) >> (62 - ab);
    endfunction
endpackage
`default_nettype wire

// ===== src/hec_if.sv =====
// Request and response channel interfaces of the coordinate converter.
`default_nettype none
interface hec_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic        [hec_pkg::PORT_BITS-1:0] around_angle;
    logic signed [hec_pkg::PORT_BITS-1:0] elevation_angle;
    logic        [hec_pkg::PORT_BITS-1:0] sidereal_angle;

    modport source(output valid, operation, around_angle, elevation_angle, sidereal_angle,
                   input ready);
    modport sink(input valid, operation, around_angle, elevation_angle, sidereal_angle,
                 output ready);
endinterface

interface hec_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic        [hec_pkg::PORT_BITS-1:0] result_around;
    logic signed [hec_pkg::PORT_BITS-1:0] result_elevation;

    modport source(output valid, result_around, result_elevation, input ready);
    modport sink(input valid, result_around, result_elevation, output ready);
endinterface
`default_nettype wire

// ===== src/hec_rotate.sv =====
// Pipelined rotation-mode CORDIC giving sine and cosine of a binary angle.
`default_nettype none
module hec_rotate #(
    parameter int ANGLE_BITS = hec_pkg::ANGLE_BITS,
    parameter int STAGES     = hec_pkg::CORDIC_STAGES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [ANGLE_BITS-1:0] i_angle,
    output hec_pkg::t_val              o_sin,
    output hec_pkg::t_val              o_cos
);
    localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    logic [1:0]            w_quad;
    logic                  w_neg;
    logic [ANGLE_BITS-1:0] w_fold;

    hec_pkg::t_val                r_x   [0:STAGES];
    hec_pkg::t_val                r_y   [0:STAGES];
    logic signed [ANGLE_BITS-1:0] r_z   [0:STAGES];
    logic                         r_neg [0:STAGES];

    assign w_quad = i_angle[ANGLE_BITS-1 -: 2];
    assign w_neg  = (w_quad == 2'd1) || (w_quad == 2'd2);
    assign w_fold = w_neg ? i_angle + HALF : i_angle;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= hec_pkg::VAL_BITS'(hec_pkg::CORDIC_GAIN);
            r_y[0]   <= '0;
            r_z[0]   <= $signed(w_fold);
            r_neg[0] <= w_neg;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ANGLE_BITS-1:0] STEP =
            ANGLE_BITS'(hec_pkg::step_angle(i, ANGLE_BITS));
        hec_pkg::t_val                w_xs, w_ys, n_x, n_y;
        logic signed [ANGLE_BITS-1:0] n_z;

        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;
        assign n_x  = r_z[i][ANGLE_BITS-1] ? r_x[i] + w_ys : r_x[i] - w_ys;
        assign n_y  = r_z[i][ANGLE_BITS-1] ? r_y[i] - w_xs : r_y[i] + w_xs;
        assign n_z  = r_z[i][ANGLE_BITS-1] ? r_z[i] + STEP : r_z[i] - STEP;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_z[i+1]   <= n_z;
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    assign o_sin = r_neg[STAGES] ? -r_y[STAGES] : r_y[STAGES];
    assign o_cos = r_neg[STAGES] ? -r_x[STAGES] : r_x[STAGES];
endmodule
`default_nettype wire

// ===== src/hec_vector.sv =====
// Pipelined vectoring-mode CORDIC giving atan2 as a binary angle.
`default_nettype none
module hec_vector #(
    parameter int ANGLE_BITS = hec_pkg::ANGLE_BITS,
    parameter int STAGES     = hec_pkg::CORDIC_STAGES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire hec_pkg::t_val          i_y,
    input  wire hec_pkg::t_val          i_x,
    output logic       [ANGLE_BITS-1:0] o_angle
);
    localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    hec_pkg::t_val         r_x    [0:STAGES];
    hec_pkg::t_val         r_y    [0:STAGES];
    logic [ANGLE_BITS-1:0] r_z    [0:STAGES];
    logic                  r_zero [0:STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[hec_pkg::VAL_BITS-1]) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= HALF;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic [ANGLE_BITS-1:0] STEP =
            ANGLE_BITS'(hec_pkg::step_angle(i, ANGLE_BITS));
        hec_pkg::t_val         w_xs, w_ys, n_x, n_y;
        logic [ANGLE_BITS-1:0] n_z;

        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;
        assign n_x  = r_y[i][hec_pkg::VAL_BITS-1] ? r_x[i] - w_ys : r_x[i] + w_ys;
        assign n_y  = r_y[i][hec_pkg::VAL_BITS-1] ? r_y[i] + w_xs : r_y[i] - w_xs;
        assign n_z  = r_y[i][hec_pkg::VAL_BITS-1] ? r_z[i] - STEP : r_z[i] + STEP;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    assign o_angle = r_zero[STAGES] ? '0 : r_z[STAGES];
endmodule
`default_nettype wire

// ===== src/hec_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module hec_sqrt (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [hec_pkg::RAD_BITS-1:0]      i_n,
    output logic      [hec_pkg::FRAC_BITS:0]       o_root
);
    localparam int NS = hec_pkg::SQRT_STAGES;
    localparam int RB = hec_pkg::RES_BITS;

    logic [hec_pkg::RAD_BITS-1:0] r_n   [0:NS];
    logic [RB-1:0]                r_res [0:NS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= i_n;
            r_res[0] <= '0;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam logic [RB-1:0] BIT = RB'(1) << (hec_pkg::RAD_BITS - 1 - 2 * j);
        logic [RB-1:0]                w_sum;
        logic                         w_take;
        logic [hec_pkg::RAD_BITS-1:0] n_n;
        logic [RB-1:0]                n_res;

        assign w_sum  = r_res[j] + BIT;
        assign w_take = RB'(r_n[j]) >= w_sum;
        assign n_n    = w_take ? r_n[j] - w_sum[hec_pkg::RAD_BITS-1:0] : r_n[j];
        assign n_res  = w_take ? (r_res[j] >> 1) + BIT : r_res[j] >> 1;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[j+1]   <= n_n;
                r_res[j+1] <= n_res;
            end
        end
    end

    assign o_root = r_res[NS][hec_pkg::FRAC_BITS:0];
endmodule
`default_nettype wire

// ===== src/horizontal_equatorial_convert.sv =====
// Top level of the equatorial / horizontal coordinate converter.
// Converts right ascension and declination to azimuth (from south) and altitude, or back,
// for the site latitude held in the register at byte address 0. The block is a single
// pipeline that takes one request per cycle unless stalled by a waiting result; each result
// passes through the two CORDIC chains in series and the one-bit-per-stage square root
// between them. A waiting result blocks new requests only once the stage just before the
// output register holds an item.
`default_nettype none
module horizontal_equatorial_convert #(
    parameter int ANGLE_BITS    = hec_pkg::ANGLE_BITS,
    parameter int CORDIC_STAGES = hec_pkg::CORDIC_STAGES
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    hec_req_if.sink                                  i_req,
    hec_rsp_if.source                                o_rsp,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hec_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  wire logic [hec_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic      [hec_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                     pready
);
    localparam int PB       = hec_pkg::PORT_BITS;
    localparam int VB       = hec_pkg::VAL_BITS;
    localparam int FB       = hec_pkg::FRAC_BITS;
    localparam int SQ       = hec_pkg::SQRT_STAGES;
    localparam int SHIFT    = (ANGLE_BITS >= PB) ? ANGLE_BITS - PB : PB - ANGLE_BITS;
    localparam int POS_ROT  = CORDIC_STAGES + 1;
    localparam int POS_SQRT = POS_ROT + 4 + SQ;
    localparam int POS_VEC  = POS_SQRT + 1 + CORDIC_STAGES;
    localparam int PIPE_LEN = POS_VEC + 1;
    localparam hec_pkg::t_val ONE = VB'(1) << FB;
    localparam logic [hec_pkg::RES_BITS-1:0] ONE_SQ = hec_pkg::RES_BITS'(1) << (2 * FB);
    localparam logic signed [ANGLE_BITS-1:0] ELEV_LIM = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    function automatic hec_pkg::t_val mulq(input hec_pkg::t_val a, input hec_pkg::t_val b);
        logic signed [2*VB-1:0] p;
        p = a * b;
        return VB'(p >>> FB);
    endfunction

    logic w_load_out, w_adv, w_cfg_wr, w_cfg_sel;
    logic [ANGLE_BITS-1:0] w_lat_ang, w_elev_ang, w_arnd_ang, w_sid_ang;
    hec_pkg::t_val w_sp, w_cp, w_se, w_ce, w_sa, w_ca;
    hec_pkg::t_val w_sum, n_s, w_abs;
    logic [FB:0] w_u, w_root;
    logic [hec_pkg::RES_BITS-1:0] w_uu, w_rad;
    logic [ANGLE_BITS-1:0] w_z_arnd, w_z_elev, n_around_ang;
    logic signed [ANGLE_BITS-1:0] w_elev_s, w_elev_c;
    logic [PB-1:0] n_out_around, n_out_elev;

    logic [PB-1:0]         r_lat;
    logic [PIPE_LEN-1:0]   r_vld;
    logic                  r_op  [0:PIPE_LEN-1];
    logic [ANGLE_BITS-1:0] r_sid [0:PIPE_LEN-1];
    logic [ANGLE_BITS-1:0] r_lat_ang, r_elev_ang, r_arnd_ang;
    hec_pkg::t_val r_p1, r_p2, r_p3, r_p4, r_p5, r_m1_ca, r_m1_ce, r_m1_cp;
    hec_pkg::t_val r_p6, r_p7, r_m2_p1, r_m2_p4, r_m2_p5;
    hec_pkg::t_val r_s, r_x, r_y;
    hec_pkg::t_val r_ds [0:SQ];
    hec_pkg::t_val r_dx [0:SQ];
    hec_pkg::t_val r_dy [0:SQ];
    logic          r_out_vld;
    logic [PB-1:0] r_out_around, r_out_elev;

    // Output register loads when empty or taken; the rest also moves over a bubble.
    assign w_load_out  = !r_out_vld || o_rsp.ready;
    assign w_adv       = w_load_out || !r_vld[PIPE_LEN-1];
    assign i_req.ready = w_adv;

    assign pready    = 1'b1;
    assign w_cfg_sel = paddr[hec_pkg::CFG_ADDR_BITS-1:2] == hec_pkg::REG_SITE_LATITUDE;
    assign w_cfg_wr  = psel && penable && pwrite && w_cfg_sel;
    assign prdata    = w_cfg_sel ? r_lat : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= '0;
        end else if (w_cfg_wr) begin
            r_lat <= pwdata;
        end
    end

    if (ANGLE_BITS >= PB) begin : g_in_wide
        assign w_lat_ang  = ANGLE_BITS'(r_lat) << SHIFT;
        assign w_elev_ang = ANGLE_BITS'(i_req.elevation_angle) << SHIFT;
        assign w_arnd_ang = ANGLE_BITS'(i_req.around_angle) << SHIFT;
        assign w_sid_ang  = ANGLE_BITS'(i_req.sidereal_angle) << SHIFT;
    end else begin : g_in_narrow
        assign w_lat_ang  = ANGLE_BITS'(r_lat >> SHIFT);
        assign w_elev_ang = ANGLE_BITS'(i_req.elevation_angle >> SHIFT);
        assign w_arnd_ang = ANGLE_BITS'(i_req.around_angle >> SHIFT);
        assign w_sid_ang  = ANGLE_BITS'(i_req.sidereal_angle >> SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_LEN-2:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op[0]    <= i_req.operation;
            r_sid[0]   <= w_sid_ang;
            r_lat_ang  <= w_lat_ang;
            r_elev_ang <= w_elev_ang;
            r_arnd_ang <= (i_req.operation == hec_pkg::OP_EQU_TO_HOR) ?
                          w_sid_ang - w_arnd_ang : w_arnd_ang;
            for (int k = 1; k < PIPE_LEN; k++) begin
                r_op[k]  <= r_op[k-1];
                r_sid[k] <= r_sid[k-1];
            end
        end
    end

    hec_rotate #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_rot_lat (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(r_lat_ang), .o_sin(w_sp), .o_cos(w_cp));
    hec_rotate #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_rot_elev (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(r_elev_ang), .o_sin(w_se), .o_cos(w_ce));
    hec_rotate #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_rot_arnd (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(r_arnd_ang), .o_sin(w_sa), .o_cos(w_ca));

    assign w_sum = (r_op[POS_ROT+2] == hec_pkg::OP_HOR_TO_EQU) ? r_m2_p1 - r_p6 : r_m2_p1 + r_p6;
    assign n_s   = (w_sum > ONE) ? ONE : (w_sum < -ONE) ? -ONE : w_sum;
    assign w_abs = r_s[VB-1] ? -r_s : r_s;
    assign w_u   = w_abs[FB:0];
    assign w_uu  = w_u * w_u;
    assign w_rad = ONE_SQ - w_uu;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1    <= mulq(w_se, w_sp);
            r_p2    <= (r_op[POS_ROT] == hec_pkg::OP_HOR_TO_EQU) ?
                       mulq(w_ca, w_ce) : mulq(w_ce, w_cp);
            r_p3    <= mulq(w_ca, w_sp);
            r_p4    <= mulq(w_se, w_cp);
            r_p5    <= mulq(w_sa, w_ce);
            r_m1_ca <= w_ca;
            r_m1_ce <= w_ce;
            r_m1_cp <= w_cp;

            r_p6    <= mulq(r_p2, (r_op[POS_ROT+1] == hec_pkg::OP_HOR_TO_EQU) ?
                                  r_m1_cp : r_m1_ca);
            r_p7    <= mulq(r_p3, r_m1_ce);
            r_m2_p1 <= r_p1;
            r_m2_p4 <= r_p4;
            r_m2_p5 <= r_p5;

            r_s <= n_s;
            r_x <= (r_op[POS_ROT+2] == hec_pkg::OP_HOR_TO_EQU) ?
                   r_p7 + r_m2_p4 : r_p7 - r_m2_p4;
            r_y <= r_m2_p5;

            r_ds[0] <= r_s;
            r_dx[0] <= r_x;
            r_dy[0] <= r_y;
            for (int k = 1; k <= SQ; k++) begin
                r_ds[k] <= r_ds[k-1];
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
            end
        end
    end

    hec_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(w_adv), .i_n(w_rad[hec_pkg::RAD_BITS-1:0]), .o_root(w_root));

    hec_vector #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_vec_elev (
        .i_clk(i_clk), .i_en(w_adv), .i_y(r_ds[SQ]), .i_x($signed(VB'(w_root))),
        .o_angle(w_z_elev));
    hec_vector #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_vec_arnd (
        .i_clk(i_clk), .i_en(w_adv), .i_y(r_dy[SQ]), .i_x(r_dx[SQ]), .o_angle(w_z_arnd));

    assign n_around_ang = (r_op[POS_VEC] == hec_pkg::OP_HOR_TO_EQU) ?
                          r_sid[POS_VEC] - w_z_arnd : w_z_arnd;
    assign w_elev_s = $signed(w_z_elev);
    assign w_elev_c = (w_elev_s > ELEV_LIM) ? ELEV_LIM :
                      (w_elev_s < -ELEV_LIM) ? -ELEV_LIM : w_elev_s;

    if (ANGLE_BITS >= PB) begin : g_out_wide
        assign n_out_around = PB'(n_around_ang >> SHIFT);
        assign n_out_elev   = PB'(w_elev_c >>> SHIFT);
    end else begin : g_out_narrow
        assign n_out_around = PB'(n_around_ang) << SHIFT;
        assign n_out_elev   = PB'(w_elev_c) << SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= r_vld[PIPE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_around <= n_out_around;
            r_out_elev   <= n_out_elev;
        end
    end

    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.result_around    = r_out_around;
    assign o_rsp.result_elevation = $signed(r_out_elev);
endmodule
`default_nettype wire

// ===== src/hec_checker.sv =====
// Port-level checks of the coordinate converter and their bind to the top level.
`default_nettype none
module hec_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_req_valid,
    input wire logic                             i_req_ready,
    input wire logic                             i_rsp_valid,
    input wire logic                             i_rsp_ready,
    input wire logic [hec_pkg::PORT_BITS-1:0]    i_rsp_around,
    input wire logic [hec_pkg::PORT_BITS-1:0]    i_rsp_elev,
    input wire logic                             i_pready
);
    localparam logic signed [hec_pkg::PORT_BITS-1:0] LIM = 32'sd1073741824;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_around)
                                        && $stable(i_rsp_elev))
        else $error("response changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> i_rsp_valid && !i_rsp_ready)
        else $error("request stalled without a waiting response");

    a_elev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ($signed(i_rsp_elev) <= LIM) && ($signed(i_rsp_elev) >= -LIM))
        else $error("elevation beyond ninety degrees");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid |-> i_pready)
        else $error("config port not ready");
endmodule

bind horizontal_equatorial_convert hec_checker u_hec_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_around (o_rsp.result_around),
    .i_rsp_elev   (o_rsp.result_elevation),
    .i_pready     (pready)
);
`default_nettype wire
